// ===== rtl/mwr_pkg.sv =====
// Shared types and constants for the microwire EEPROM word reader.
// No dependencies; imported by every module of the block.
package mwr_pkg;

    localparam int CMD_BITS_DEF  = 11;
    localparam int DATA_BITS_DEF = 16;

    localparam int CMD_WORD_W  = 11;
    localparam int HALF_W      = 20;
    localparam int SHIFT_W     = 5;
    localparam int SIZE_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CMD_WORD_W-1:0] CMD_WORD_RST = 11'd1553;
    localparam logic [HALF_W-1:0]     HALF_RST     = 20'd100000;
    localparam logic [SHIFT_W-1:0]    SHIFT_RST    = 5'd12;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_WORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SHIFT   = 2'd2;

    typedef struct packed {
        logic [CMD_WORD_W-1:0] command_word;
        logic [HALF_W-1:0]     half_period_ticks;
        logic [SHIFT_W-1:0]    size_shift;
    } mwr_cfg_t;

    typedef struct packed {
        logic              chip_select;
        logic              serial_clock;
        logic              serial_out;
        logic              preset_pin;
        logic              busy_res;
        logic              done_res;
        logic [SIZE_W-1:0] size_value;
        logic              present;
    } mwr_result_t;

endpackage

// ===== rtl/mwr_cfg_regs.sv =====
// Configuration register file for the microwire EEPROM word reader.
// Depends on mwr_pkg for register indexes, widths and reset values.
module mwr_cfg_regs
    import mwr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output mwr_cfg_t              cfg
);

    mwr_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.command_word      <= CMD_WORD_RST;
            cfg_reg.half_period_ticks <= HALF_RST;
            cfg_reg.size_shift        <= SHIFT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COMMAND_WORD: cfg_reg.command_word <= cfg_wr_data[CMD_WORD_W-1:0];
                CFG_HALF_PERIOD:  cfg_reg.half_period_ticks <= cfg_wr_data[HALF_W-1:0];
                CFG_SIZE_SHIFT:   cfg_reg.size_shift <= cfg_wr_data[SHIFT_W-1:0];
                default: ; // drop writes to unmapped indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/mwr_seq.sv =====
// Pin sequencer of the microwire EEPROM word reader: holds the sequence state
// and works out one tick per step. Depends on mwr_pkg.
module mwr_seq
    import mwr_pkg::*;
#(
    parameter int CMD_BITS  = CMD_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        req_type,
    input  logic        serial_in,
    input  mwr_cfg_t    cfg,
    output mwr_result_t result
);

    localparam int MAX_BITS = (CMD_BITS > DATA_BITS) ? CMD_BITS : DATA_BITS;
    localparam int BIT_W    = $clog2(MAX_BITS + 1);

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT, PH_CMD_LOW, PH_CMD_HIGH, PH_RD_ENTRY, PH_RD_LOW, PH_RD_HIGH
    } phase_t;

    phase_t                phase_reg,  phase_next;
    logic [BIT_W-1:0]      bit_reg,    bit_next;
    logic [HALF_W-1:0]     delay_reg,  delay_next;
    logic [CMD_BITS-1:0]   cmd_reg,    cmd_next;
    logic [DATA_BITS-1:0]  data_reg,   data_next;
    logic                  cs_reg,     cs_next;
    logic                  clk_reg,    clk_next;
    logic                  do_reg,     do_next;
    logic                  pre_reg,    pre_next;
    logic [SIZE_W-1:0]     size_reg,   size_next;
    logic                  done;

    logic [HALF_W-1:0]     hold_len;
    logic [HALF_W-1:0]     delay_dec;
    logic [BIT_W-1:0]      bit_inc;
    logic [DATA_BITS-1:0]  data_in;

    assign hold_len  = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
    assign delay_dec = (delay_reg != '0) ? delay_reg - HALF_W'(1) : '0;
    assign bit_inc   = bit_reg + BIT_W'(1);
    assign data_in   = DATA_BITS'({data_reg, serial_in});

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        delay_next = delay_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        cs_next    = cs_reg;
        clk_next   = clk_reg;
        do_next    = do_reg;
        pre_next   = pre_reg;
        size_next  = size_reg;
        done       = 1'b0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (req_type) begin
                    pre_next   = 1'b0;
                    do_next    = 1'b0;
                    clk_next   = 1'b0;
                    delay_next = hold_len;
                    data_next  = '0;
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT: begin
                delay_next = delay_dec;
                if (delay_dec == '0) begin
                    cs_next    = 1'b1;
                    clk_next   = 1'b1;
                    cmd_next   = CMD_BITS'(cfg.command_word);
                    bit_next   = '0;
                    phase_next = PH_CMD_LOW;
                end
            end
            PH_CMD_LOW: begin
                do_next    = cmd_reg[CMD_BITS-1];
                clk_next   = 1'b0;
                phase_next = PH_CMD_HIGH;
            end
            PH_CMD_HIGH: begin
                clk_next   = 1'b1;
                cmd_next   = cmd_reg << 1;
                bit_next   = bit_inc;
                phase_next = (bit_inc >= BIT_W'(CMD_BITS)) ? PH_RD_ENTRY : PH_CMD_LOW;
            end
            PH_RD_ENTRY: begin
                do_next    = 1'b0;
                clk_next   = 1'b0;
                delay_next = hold_len;
                bit_next   = '0;
                data_next  = '0;
                phase_next = PH_RD_LOW;
            end
            PH_RD_LOW: begin
                delay_next = delay_dec;
                if (delay_dec == '0) begin
                    clk_next   = 1'b1;
                    delay_next = hold_len;
                    phase_next = PH_RD_HIGH;
                end
            end
            PH_RD_HIGH: begin
                delay_next = delay_dec;
                if (delay_dec == '0) begin
                    // sample at the end of the high half
                    data_next = data_in;
                    bit_next  = bit_inc;
                    if (bit_inc >= BIT_W'(DATA_BITS)) begin
                        cs_next    = 1'b0;
                        do_next    = 1'b0;
                        pre_next   = 1'b1;
                        clk_next   = 1'b1;
                        size_next  = SIZE_W'(data_in) << cfg.size_shift;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        clk_next   = 1'b0;
                        delay_next = hold_len;
                        phase_next = PH_RD_LOW;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bit_reg   <= '0;
            delay_reg <= '0;
            cmd_reg   <= '0;
            data_reg  <= '0;
            cs_reg    <= 1'b0;
            clk_reg   <= 1'b0;
            do_reg    <= 1'b0;
            pre_reg   <= 1'b0;
            size_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            delay_reg <= delay_next;
            cmd_reg   <= cmd_next;
            data_reg  <= data_next;
            cs_reg    <= cs_next;
            clk_reg   <= clk_next;
            do_reg    <= do_next;
            pre_reg   <= pre_next;
            size_reg  <= size_next;
        end
    end

    always_comb begin
        result.chip_select  = cs_next;
        result.serial_clock = clk_next;
        result.serial_out   = do_next;
        result.preset_pin   = pre_next;
        result.busy_res     = (phase_next != PH_IDLE);
        result.done_res     = done;
        result.size_value   = size_next;
        result.present      = (size_next != '0);
    end

endmodule

// ===== rtl/microwire_eeprom_word_reader_unit.sv =====
// Top level of the microwire EEPROM word reader.
// Depends on mwr_pkg, mwr_cfg_regs and mwr_seq.
//
// Each input beat is one time-base tick; every accepted beat yields exactly
// one result beat carrying the pin levels after that tick, the busy and done
// flags, and the last read word shifted left by size_shift. A beat with
// req_type set starts a read when the sequencer is idle and is otherwise
// treated as a plain tick. The block takes one beat per clock cycle unless m_ready
// holds the output back: a beat lands in the input register, the sequencer works
// out the tick in one pass and the result is registered in the output register,
// where it is held until taken. Only m_ready low stalls the flow. The input
// register refills while the output register still holds an untaken result,
// either when the input register is empty or, when it still holds a beat, as long
// as the output side frees up in the same cycle. Configuration is a plain
// write port (no read-back) and should only be written while no beat is in
// flight.
module microwire_eeprom_word_reader_unit
    import mwr_pkg::*;
#(
    parameter int CMD_BITS  = CMD_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input ticks
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic                  s_serial_in,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_chip_select,
    output logic                  m_serial_clock,
    output logic                  m_serial_out,
    output logic                  m_preset_pin,
    output logic                  m_busy_res,
    output logic                  m_done_res,
    output logic [SIZE_W-1:0]     m_size_value,
    output logic                  m_present
);

    mwr_cfg_t    cfg;
    mwr_result_t step_result;
    mwr_result_t res_reg;

    logic in_valid_reg;
    logic req_reg;
    logic sin_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    // Run the sequencer on the buffered tick whenever its result has a home.
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    mwr_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    mwr_seq #(
        .CMD_BITS  (CMD_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .req_type  (req_reg),
        .serial_in (sin_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    // Input register: hold the tick until the sequencer consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req_type;
            sin_reg <= s_serial_in;
        end
    end

    // Output register: load on advance, drop the valid once the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_chip_select  = res_reg.chip_select;
    assign m_serial_clock = res_reg.serial_clock;
    assign m_serial_out   = res_reg.serial_out;
    assign m_preset_pin   = res_reg.preset_pin;
    assign m_busy_res     = res_reg.busy_res;
    assign m_done_res     = res_reg.done_res;
    assign m_size_value   = res_reg.size_value;
    assign m_present      = res_reg.present;

endmodule
